### sv/upsp_pkg.sv
// Shared types, codes and varint helpers for the UPS patch stream parser.
package upsp_pkg;

	localparam logic [1:0] KIND_SIZES = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_MAGIC  = 2'd0;
	localparam logic [1:0] ERR_VARINT = 2'd1;
	localparam logic [1:0] ERR_TRUNC  = 2'd2;

	localparam logic [35:0] VSAT_WIDE  = 36'h1_0000_0000;
	localparam logic [32:0] VSAT       = 33'h1_0000_0000;
	localparam logic [32:0] VLIMIT     = 33'h0_FFFF_FFFF;
	localparam logic [2:0]  SHIFT_LAST = 3'd4;
	localparam logic [2:0]  SHIFT_SAT  = 3'd5;
	localparam logic [1:0]  MAGIC_END  = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  xor_value;
		logic [31:0] source_size;
		logic [31:0] target_size;
		logic [1:0]  error_code;
	} upsp_result_t;

	typedef struct packed {
		logic        done;
		logic [32:0] acc;
		logic [2:0]  shift;
	} upsp_varint_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h55;
			2'd1:    r = 8'h50;
			2'd2:    r = 8'h53;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

	// x << (7 * shift), shift in 0..4
	function automatic logic [35:0] shl7(input logic [6:0] x, input logic [2:0] shift);
		logic [35:0] r;
		case (shift)
			3'd0:    r = {29'd0, x};
			3'd1:    r = {22'd0, x, 7'd0};
			3'd2:    r = {15'd0, x, 14'd0};
			3'd3:    r = {8'd0, x, 21'd0};
			3'd4:    r = {1'b0, x, 28'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [32:0] sat33(input logic [35:0] x);
		return (x > VSAT_WIDE) ? VSAT : x[32:0];
	endfunction

	// one byte of a UPS varint; accumulator saturates at 2^32
	function automatic upsp_varint_t varint_step(input logic [32:0] acc,
			input logic [2:0] shift, input logic [7:0] b);
		upsp_varint_t r;
		logic [35:0]  sum;
		logic [32:0]  a1;
		logic [2:0]   sh1;
		if (shift <= SHIFT_LAST) begin
			sum = {3'd0, acc} + shl7(b[6:0], shift);
		end else begin
			sum = VSAT_WIDE;
		end
		a1 = sat33(sum);
		r.done  = b[7];
		r.acc   = a1;
		r.shift = '0;
		if (!b[7]) begin
			sh1 = (shift >= SHIFT_LAST) ? SHIFT_SAT : shift + 3'd1;
			if (sh1 <= SHIFT_LAST) begin
				sum = {3'd0, a1} + shl7(7'd1, sh1);
			end else begin
				sum = VSAT_WIDE;
			end
			r.acc   = sat33(sum);
			r.shift = sh1;
		end
		return r;
	endfunction

endpackage

### sv/upsp_decode.sv
// Parse state and per-word decode of the UPS header, sizes and records.
module upsp_decode #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               patch_byte,
	input  logic                     last_byte,
	output upsp_pkg::upsp_result_t   res,
	output logic [ADDR_WIDTH-1:0]    res_addr
);
	import upsp_pkg::*;

	typedef enum logic [2:0] {
		PH_MAGIC, PH_SRC, PH_TGT, PH_OFS, PH_DATA, PH_DONE, PH_ERR
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [1:0]            magic_idx_q, magic_idx_n;
	logic [32:0]           acc_q, acc_n;
	logic [2:0]            shift_q, shift_n;
	logic [31:0]           src_q, src_n;
	logic [31:0]           tgt_q, tgt_n;
	logic [ADDR_WIDTH-1:0] addr_q, addr_n;
	upsp_varint_t          vs;
	logic                  has_err;
	logic [1:0]            err;

	always_comb begin
		phase_n     = phase_q;
		magic_idx_n = magic_idx_q;
		acc_n       = acc_q;
		shift_n     = shift_q;
		src_n       = src_q;
		tgt_n       = tgt_q;
		addr_n      = addr_q;
		has_err     = 1'b0;
		err         = ERR_MAGIC;
		res         = '0;
		res_addr    = '0;
		vs          = varint_step(acc_q, shift_q, patch_byte);

		unique case (phase_q)
			PH_MAGIC: begin
				if (patch_byte != magic_byte(magic_idx_q)) begin
					has_err = 1'b1;
					err     = ERR_MAGIC;
				end else if (magic_idx_q == MAGIC_END) begin
					magic_idx_n = '0;
					phase_n     = PH_SRC;
				end else begin
					magic_idx_n = magic_idx_q + 2'd1;
				end
			end
			PH_SRC, PH_TGT, PH_OFS: begin
				if (!vs.done) begin
					acc_n   = vs.acc;
					shift_n = vs.shift;
				end else begin
					acc_n   = '0;
					shift_n = '0;
					if (vs.acc >= VLIMIT) begin
						has_err = 1'b1;
						err     = ERR_VARINT;
					end else if (phase_q == PH_SRC) begin
						src_n   = vs.acc[31:0];
						phase_n = PH_TGT;
					end else if (phase_q == PH_TGT) begin
						tgt_n     = vs.acc[31:0];
						phase_n   = PH_OFS;
						res.valid = 1'b1;
						res.kind  = KIND_SIZES;
					end else if (vs.acc >= {1'b0, tgt_q}) begin
						phase_n   = PH_DONE;
						res.valid = 1'b1;
						res.kind  = KIND_END;
					end else begin
						addr_n  = addr_q + vs.acc[ADDR_WIDTH-1:0];
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (patch_byte == 8'h00) begin
					phase_n = PH_OFS;
				end else begin
					res.valid     = 1'b1;
					res.kind      = KIND_DATA;
					res.xor_value = patch_byte;
					res_addr      = addr_q;
				end
				addr_n = addr_q + ADDR_WIDTH'(1);
			end
			default: ;
		endcase

		if (!has_err && last_byte && phase_n != PH_DONE && phase_n != PH_ERR) begin
			has_err = 1'b1;
			err     = ERR_TRUNC;
		end
		if (has_err) begin
			res.valid     = 1'b1;
			res.kind      = KIND_ERROR;
			res.xor_value = '0;
			res.error_code = err;
			res_addr      = '0;
			phase_n       = PH_ERR;
		end
		if (res.kind == KIND_SIZES) begin
			res.source_size = src_n;
			res.target_size = tgt_n;
		end

		// end of patch: back to a fresh header
		if (last_byte) begin
			phase_n     = PH_MAGIC;
			magic_idx_n = '0;
			acc_n       = '0;
			shift_n     = '0;
			src_n       = '0;
			tgt_n       = '0;
			addr_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			magic_idx_q <= '0;
			acc_q       <= '0;
			shift_q     <= '0;
			src_q       <= '0;
			tgt_q       <= '0;
			addr_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			magic_idx_q <= magic_idx_n;
			acc_q       <= acc_n;
			shift_q     <= shift_n;
			src_q       <= src_n;
			tgt_q       <= tgt_n;
			addr_q      <= addr_n;
		end
	end

endmodule

### sv/ups_patch_stream_parser.sv
// UPS patch stream parser top level: input register, decoder, result register.
// An accepted word passes from the input register through the decoder into the result register, which drives out_valid.
// Throughput: one word per cycle unless a waiting result is not taken; input and result registers stall together.
// A word may be taken while a result still waits, when the input register is free.
// Reset (arst_n low): parser back to expecting the magic, both registers empty.
module ups_patch_stream_parser #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            patch_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [ADDR_WIDTH-1:0] target_address,
	output logic [7:0]            xor_value,
	output logic [31:0]           source_size,
	output logic [31:0]           target_size,
	output logic [1:0]            error_code
);
	import upsp_pkg::*;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  advance;
	logic                  step;
	upsp_result_t          res;
	logic [ADDR_WIDTH-1:0] res_addr;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [7:0]            xor_q;
	logic [31:0]           src_q;
	logic [31:0]           tgt_q;
	logic [1:0]            err_q;

	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= patch_byte;
			last_s1 <= last_byte;
		end
	end

	upsp_decode #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.patch_byte (byte_s1),
		.last_byte  (last_s1),
		.res        (res),
		.res_addr   (res_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q <= res.kind;
			addr_q <= res_addr;
			xor_q  <= res.xor_value;
			src_q  <= res.source_size;
			tgt_q  <= res.target_size;
			err_q  <= res.error_code;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign target_address = addr_q;
	assign xor_value      = xor_q;
	assign source_size    = src_q;
	assign target_size    = tgt_q;
	assign error_code     = err_q;

	a_sizes_only_with_kind0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SIZES |-> source_size == 32'd0 && target_size == 32'd0)
		else $error("size fields set on a non-size word");

	a_err_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |->
			error_code == ERR_MAGIC || error_code == ERR_VARINT || error_code == ERR_TRUNC)
		else $error("bad error code");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a word under stall");

endmodule

### tb/sv/tb_ups_patch_stream_parser.sv
// Self-checking testbench for the UPS patch stream parser: random patches, stalls, field checks.
module tb_ups_patch_stream_parser;
	import upsp_pkg::*;

	localparam int LIMIT = 400000;
	localparam int CALM_LO = 600;
	localparam int CALM_HI = 1100;
	localparam logic [31:0] MAGIC_WORD = 32'h5550_5331;
	localparam logic [40:0] ACC_SAT = 41'h1_0000_0000;
	localparam logic [40:0] ACC_LIMIT = 41'h0_FFFF_FFFF;
	localparam longint unsigned SIZE_MAX = 64'hFFFF_FFFE;

	typedef enum logic [2:0] {
		ST_MAGIC, ST_SRC_SIZE, ST_TGT_SIZE, ST_OFFSET, ST_XOR, ST_CRC, ST_FAULT
	} parse_state_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [7:0]  xv;
		logic [31:0] src;
		logic [31:0] tgt;
		logic [1:0]  code;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  patch_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] target_address;
	logic [7:0]  xor_value;
	logic [31:0] source_size;
	logic [31:0] target_size;
	logic [1:0]  error_code;

	stream_word_t  patch_stream[$];
	parse_result_t results_due[$];
	logic [7:0]    pbuf[$];
	stream_word_t  next_word;
	parse_result_t got_result;

	parse_state_e ps;
	logic [1:0]   mag_idx;
	logic [40:0]  vacc;
	int           vsh;
	logic [31:0]  src_sz;
	logic [31:0]  tgt_sz;
	logic [31:0]  cur_addr;

	int cyc = 0;
	int errors = 0;
	int bytes_taken = 0;
	int patches = 0;
	int clean_patches = 0;
	int kinds_seen[4] = '{0, 0, 0, 0};

	ups_patch_stream_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.patch_byte(patch_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.target_address(target_address),
		.xor_value(xor_value),
		.source_size(source_size),
		.target_size(target_size),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	function automatic bit take_break();
		if (cyc >= CALM_LO && cyc < CALM_HI)
			return 1'b0;
		return $urandom_range(0, 99) < 34;
	endfunction

	task automatic put_byte(input logic [7:0] x);
		pbuf.insert(pbuf.size(), x);
	endtask

	task automatic restart_parse();
		ps = ST_MAGIC;
		mag_idx = '0;
		vacc = '0;
		vsh = 0;
		src_sz = '0;
		tgt_sz = '0;
		cur_addr = '0;
	endtask

	// expected result of one accepted word
	task automatic parse_byte(input logic [7:0] b, input logic last);
		parse_result_t r;
		logic          emit;
		logic          fault;
		logic [1:0]    code;
		logic [40:0]   v;
		r = '0;
		emit = 1'b0;
		fault = 1'b0;
		code = ERR_MAGIC;
		case (ps)
			ST_MAGIC: begin
				if (b != MAGIC_WORD[8 * (3 - int'(mag_idx)) +: 8]) begin
					fault = 1'b1;
					code = ERR_MAGIC;
				end else if (mag_idx == 2'd3) begin
					mag_idx = '0;
					ps = ST_SRC_SIZE;
				end else begin
					mag_idx = mag_idx + 2'd1;
				end
			end
			ST_SRC_SIZE, ST_TGT_SIZE, ST_OFFSET: begin
				if (vsh <= 28)
					vacc = vacc + ({34'd0, b[6:0]} << vsh);
				else
					vacc = ACC_SAT;
				if (vacc > ACC_SAT)
					vacc = ACC_SAT;
				if (!b[7]) begin
					vsh = (vsh + 7 > 35) ? 35 : vsh + 7;
					if (vsh <= 28)
						vacc = vacc + (41'd1 << vsh);
					else
						vacc = ACC_SAT;
					if (vacc > ACC_SAT)
						vacc = ACC_SAT;
				end else begin
					vsh = 0;
					v = vacc;
					vacc = '0;
					if (v >= ACC_LIMIT) begin
						fault = 1'b1;
						code = ERR_VARINT;
					end else if (ps == ST_SRC_SIZE) begin
						src_sz = v[31:0];
						ps = ST_TGT_SIZE;
					end else if (ps == ST_TGT_SIZE) begin
						tgt_sz = v[31:0];
						ps = ST_OFFSET;
						emit = 1'b1;
						r.kind = KIND_SIZES;
						r.src = src_sz;
						r.tgt = tgt_sz;
					end else if (v[31:0] >= tgt_sz) begin
						ps = ST_CRC;
						emit = 1'b1;
						r.kind = KIND_END;
					end else begin
						cur_addr = cur_addr + v[31:0];
						ps = ST_XOR;
					end
				end
			end
			ST_XOR: begin
				if (b == 8'h00) begin
					ps = ST_OFFSET;
				end else begin
					emit = 1'b1;
					r.kind = KIND_DATA;
					r.addr = cur_addr;
					r.xv = b;
				end
				cur_addr = cur_addr + 32'd1;
			end
			default: ;
		endcase
		if (!fault && last && ps <= ST_XOR) begin
			fault = 1'b1;
			code = ERR_TRUNC;
		end
		if (fault) begin
			emit = 1'b1;
			r = '0;
			r.kind = KIND_ERROR;
			r.code = code;
			ps = ST_FAULT;
		end
		if (emit)
			results_due.insert(results_due.size(), r);
		if (last)
			restart_parse();
	endtask

	task automatic put_varint(input longint unsigned v);
		logic [7:0] x;
		forever begin
			x = 8'(v & 64'h7F);
			v = v >> 7;
			if (v == 0) begin
				put_byte(x | 8'h80);
				break;
			end
			put_byte(x);
			v = v - 1;
		end
	endtask

	task automatic put_magic();
		for (int i = 3; i >= 0; i--)
			put_byte(MAGIC_WORD[8 * i +: 8]);
	endtask

	task automatic send_patch();
		stream_word_t w;
		for (int i = 0; i < pbuf.size(); i++) begin
			w.data = pbuf[i];
			w.last = (i == pbuf.size() - 1);
			patch_stream.insert(patch_stream.size(), w);
		end
		pbuf.delete();
		patches++;
	endtask

	// well-formed patch in pbuf; body_len excludes the checksum tail
	task automatic build_patch(output int body_len);
		longint unsigned src, tgt, ofs, end_ofs;
		int sel, nrec, nx;
		pbuf.delete();
		put_magic();
		sel = $urandom_range(0, 9);
		if (sel == 0)
			src = 0;
		else if (sel == 1)
			src = SIZE_MAX;
		else if (sel < 4)
			src = $urandom_range(0, 32'hFFFF_FFFE);
		else
			src = $urandom_range(0, 4095);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			tgt = 0;
		else if (sel == 1)
			tgt = SIZE_MAX;
		else if (sel < 4)
			tgt = $urandom_range(1, 32'hFFFF_FFFE);
		else
			tgt = $urandom_range(1, 64);
		put_varint(src);
		put_varint(tgt);
		nrec = (tgt == 0) ? 0 : $urandom_range(0, 4);
		for (int k = 0; k < nrec; k++) begin
			ofs = $urandom_range(0, 32'(tgt - 1));
			put_varint(ofs);
			nx = $urandom_range(0, 5);
			for (int j = 0; j < nx; j++)
				put_byte(8'($urandom_range(1, 255)));
			put_byte(8'h00);
		end
		if ($urandom_range(0, 7) == 0)
			end_ofs = SIZE_MAX;
		else
			end_ofs = tgt + $urandom_range(0, 3);
		if (end_ofs > SIZE_MAX)
			end_ofs = SIZE_MAX;
		put_varint(end_ofs);
		body_len = pbuf.size();
		nx = $urandom_range(0, 6);
		for (int j = 0; j < nx; j++)
			put_byte(8'($urandom));
	endtask

	task automatic random_part(input int quota);
		int counted, sel, body, cut, n, stage;
		counted = 0;
		while (counted < quota) begin
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				build_patch(body);
				clean_patches++;
			end else if (sel < 80) begin
				build_patch(body);
				cut = $urandom_range(0, body - 1);
				while (pbuf.size() > cut + 1)
					void'(pbuf.pop_back());
			end else if (sel < 88) begin
				build_patch(body);
				cut = $urandom_range(0, body - 1);
				pbuf[cut] = pbuf[cut] ^ 8'($urandom_range(1, 255));
			end else if (sel < 94) begin
				// oversized varint in the source, target or offset field
				pbuf.delete();
				put_magic();
				stage = $urandom_range(0, 2);
				for (int k = 0; k < stage; k++)
					put_varint($urandom_range(1, 100));
				case ($urandom_range(0, 2))
					0: put_varint(64'hFFFF_FFFF);
					1: put_varint(64'hFFFF_FFFF + $urandom);
					default: begin
						n = $urandom_range(5, 8);
						for (int j = 0; j < n; j++)
							put_byte(8'($urandom_range(0, 127)));
						put_byte(8'($urandom_range(128, 255)));
					end
				endcase
				n = $urandom_range(0, 3);
				for (int j = 0; j < n; j++)
					put_byte(8'($urandom));
			end else begin
				pbuf.delete();
				if ($urandom_range(0, 1)) begin
					n = $urandom_range(1, 3);
					for (int i = 3; i >= 4 - n; i--)
						put_byte(MAGIC_WORD[8 * i +: 8]);
				end
				n = $urandom_range(1, 8);
				for (int j = 0; j < n; j++)
					put_byte(8'($urandom));
			end
			counted += pbuf.size();
			send_patch();
		end
	endtask

	task automatic wait_drained();
		while (patch_stream.size() != 0 || in_valid || results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			patch_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(patch_byte, last_byte);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (patch_stream.size() != 0 && !take_break()) begin
					next_word = patch_stream.pop_front();
					in_valid <= 1'b1;
					patch_byte <= next_word.data;
					last_byte <= next_word.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !take_break();
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected word, expected none actual kind %0d",
						$time, kind);
					errors++;
				end else begin
					got_result = results_due.pop_front();
					check_field("kind", 32'(got_result.kind), 32'(kind));
					check_field("target_address", got_result.addr, target_address);
					check_field("xor_value", 32'(got_result.xv), 32'(xor_value));
					check_field("source_size", got_result.src, source_size);
					check_field("target_size", got_result.tgt, target_size);
					check_field("error_code", 32'(got_result.code), 32'(error_code));
					kinds_seen[kind]++;
				end
			end
		end
	end

	initial begin
		restart_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// bad magic on the second byte
		pbuf = '{8'h55, 8'h58};
		send_patch();
		// zero sizes, empty record list, checksum byte ignored
		put_magic();
		put_byte(8'h80);
		put_byte(8'h80);
		put_byte(8'h80);
		put_byte(8'hFF);
		send_patch();
		// largest source size, xor extremes, cut off on an xor byte
		put_magic();
		put_varint(SIZE_MAX);
		put_byte(8'h83);
		put_byte(8'h81);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h80);
		put_byte(8'h01);
		send_patch();
		wait_drained();

		random_part(425);
		wait_drained();
		random_part(425);
		wait_drained();
		repeat (12) @(posedge clk);

		$display("Parsed %0d bytes in %0d patches (%0d well-formed)",
			bytes_taken, patches, clean_patches);
		$display("Words checked: %0d sizes, %0d xor, %0d end, %0d error",
			kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
		if (errors == 0 && results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/upsp_pkg.sv
sv/upsp_decode.sv
sv/ups_patch_stream_parser.sv
tb/sv/tb_ups_patch_stream_parser.sv
